FILE: hw/rtl/tcw_pkg.sv
// Shared constants, types and address helper for the text console writer.
package tcw_pkg;

    localparam int ROWS   = 25;
    localparam int COLS   = 80;
    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef logic [ADDR_W-1:0] t_addr;

    // One result item as it leaves the sequencer.
    typedef struct packed {
        logic              wrote;
        logic [ROW_W-1:0]  cell_row;
        logic [COL_W-1:0]  cell_col;
        logic [CHAR_W-1:0] cell_char;
        logic              scrolled;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
    } t_result;

    // One cycle's access to the screen store: one write port, one read port.
    typedef struct packed {
        logic              we;
        t_addr             waddr;
        logic [CHAR_W-1:0] wdata;
        t_addr             raddr;
    } t_ram_req;

    // Linear cell address, row-major. Rows and columns out of range wrap and
    // must be screened by the caller.
    function automatic t_addr cell_index(input logic [ROW_W-1:0] row,
                                         input logic [COL_W-1:0] col);
        t_addr idx;
        idx = t_addr'(row) * t_addr'(COLS) + t_addr'(col);
        return idx;
    endfunction

endpackage

FILE: hw/rtl/tcw_screen_ram.sv
// Screen character store: one write port and one registered read port.
module tcw_screen_ram (
    input  logic                         i_clk,
    input  tcw_pkg::t_ram_req            i_req,
    output logic [tcw_pkg::CHAR_W-1:0]   o_rdata
);

    logic [tcw_pkg::CHAR_W-1:0] r_mem [tcw_pkg::CELLS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

FILE: hw/rtl/tcw_ctrl.sv
// Sequencer for the console: cursor, store clearing, scrolling and cell access.
module tcw_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_op,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_char,
    input  logic [tcw_pkg::ROW_W-1:0]    i_rd_row,
    input  logic [tcw_pkg::COL_W-1:0]    i_rd_col,
    output tcw_pkg::t_result             o_res,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output tcw_pkg::t_ram_req            o_ram,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_rdata
);

    localparam logic [2:0] S_CLR    = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_SCRD   = 3'd3;
    localparam logic [2:0] S_SCWR   = 3'd4;
    localparam logic [2:0] S_WRITE  = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    localparam tcw_pkg::t_addr LAST_CELL  = tcw_pkg::t_addr'(tcw_pkg::CELLS - 1);
    localparam tcw_pkg::t_addr COPY_LIMIT =
        tcw_pkg::t_addr'(tcw_pkg::CELLS - tcw_pkg::COLS);

    logic [2:0]                   r_state;
    tcw_pkg::t_addr               r_ptr;
    logic [tcw_pkg::ROW_W-1:0]    r_cur_row;
    logic [tcw_pkg::COL_W-1:0]    r_cur_col;
    logic                         r_op;
    logic [tcw_pkg::CHAR_W-1:0]   r_char;
    logic [tcw_pkg::ROW_W-1:0]    r_rd_row;
    logic [tcw_pkg::COL_W-1:0]    r_rd_col;
    logic                         r_scr;
    tcw_pkg::t_result             r_res;

    logic                         is_nl;
    logic                         step_row;
    logic [tcw_pkg::ROW_W:0]      n_row;
    logic                         need_scroll;
    logic                         rd_in_range;

    assign is_nl       = (r_char == tcw_pkg::NEWLINE_CODE);
    assign step_row    = is_nl || (r_cur_col >= tcw_pkg::COL_W'(tcw_pkg::COLS));
    assign n_row       = step_row ? ({1'b0, r_cur_row} + 1'b1) : {1'b0, r_cur_row};
    assign need_scroll = (n_row >= (tcw_pkg::ROW_W+1)'(tcw_pkg::ROWS));
    assign rd_in_range = (r_rd_row < tcw_pkg::ROW_W'(tcw_pkg::ROWS)) &&
                         (r_rd_col < tcw_pkg::COL_W'(tcw_pkg::COLS));

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_RESULT);
    assign o_res       = r_res;

    always_comb begin
        o_ram.we    = 1'b0;
        o_ram.waddr = r_ptr;
        o_ram.wdata = '0;
        o_ram.raddr = tcw_pkg::cell_index(i_rd_row, i_rd_col);
        case (r_state)
            S_CLR: begin
                o_ram.we = 1'b1;
            end
            S_SCRD: begin
                o_ram.raddr = r_ptr + tcw_pkg::t_addr'(tcw_pkg::COLS);
            end
            S_SCWR: begin
                o_ram.we    = 1'b1;
                o_ram.wdata = (r_ptr < COPY_LIMIT) ? i_rdata : '0;
            end
            S_WRITE: begin
                o_ram.we    = !is_nl;
                o_ram.waddr = tcw_pkg::cell_index(r_cur_row, r_cur_col);
                o_ram.wdata = r_char;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_ptr     <= '0;
            r_cur_row <= '0;
            r_cur_col <= '0;
        end else begin
            case (r_state)
                S_CLR: begin
                    if (r_ptr == LAST_CELL) begin
                        r_ptr   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_op     <= i_op;
                        r_char   <= i_char;
                        r_rd_row <= i_rd_row;
                        r_rd_col <= i_rd_col;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_op == tcw_pkg::OP_READ) begin
                        r_res.wrote      <= 1'b0;
                        r_res.cell_row   <= r_rd_row;
                        r_res.cell_col   <= r_rd_col;
                        r_res.cell_char  <= rd_in_range ? i_rdata : '0;
                        r_res.scrolled   <= 1'b0;
                        r_res.cursor_row <= r_cur_row;
                        r_res.cursor_col <= r_cur_col;
                        r_state          <= S_RESULT;
                    end else begin
                        r_scr <= need_scroll;
                        if (need_scroll) begin
                            r_cur_row <= tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
                            r_cur_col <= '0;
                            r_ptr     <= '0;
                            r_state   <= S_SCRD;
                        end else begin
                            r_cur_row <= n_row[tcw_pkg::ROW_W-1:0];
                            if (step_row) begin
                                r_cur_col <= '0;
                            end
                            r_state <= S_WRITE;
                        end
                    end
                end
                S_SCRD: begin
                    r_state <= S_SCWR;
                end
                S_SCWR: begin
                    if (r_ptr == LAST_CELL) begin
                        r_ptr   <= '0;
                        r_state <= S_WRITE;
                    end else begin
                        r_ptr   <= r_ptr + 1'b1;
                        r_state <= S_SCRD;
                    end
                end
                S_WRITE: begin
                    r_res.scrolled   <= r_scr;
                    r_res.cursor_row <= r_cur_row;
                    if (is_nl) begin
                        r_res.wrote      <= 1'b0;
                        r_res.cell_row   <= '0;
                        r_res.cell_col   <= '0;
                        r_res.cell_char  <= '0;
                        r_res.cursor_col <= r_cur_col;
                    end else begin
                        r_res.wrote      <= 1'b1;
                        r_res.cell_row   <= r_cur_row;
                        r_res.cell_col   <= r_cur_col;
                        r_res.cell_char  <= r_char;
                        r_res.cursor_col <= r_cur_col + 1'b1;
                        r_cur_col        <= r_cur_col + 1'b1;
                    end
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/text_console_writer_unit.sv
// Top level of the 80x25 text console writer with its output register.
//
// Items arrive on the slave stream (i_s_*). tuser carries the operation:
// 0 puts char_code at the cursor, 1 reads one screen cell. Every item gives
// exactly one result transfer on the master stream (o_m_*), in order.
// A put of newline moves the cursor to the start of the next row. Any other
// byte first wraps to the next row if the cursor column has reached 80, and
// is then stored at the cursor, which advances by one column. Leaving the
// bottom row scrolls the whole screen up one row and clears the bottom row.
// A read goes from S_EXEC to S_RESULT; a put without scroll goes through
// S_EXEC, S_WRITE and S_RESULT. A scroll walks the store through the
// single screen memory port pair, reading then writing each cell.
// The sequencer handles one item at a time, so o_s_tready is high only
// while it is idle; the next item may be accepted while a finished result
// waits in the output register.
// After reset the screen memory is cleared one cell per cycle, and
// o_s_tready stays low meanwhile. The cursor resets to row 0, column 0.
// If the receiver stalls, the result holds in the output register, and the
// sequencer holds its next result until that register drains.
module text_console_writer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic        i_s_tuser,   // op
    input  logic [23:0] i_s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic        o_m_tuser,   // wrote
    output logic [39:0] o_m_tdata    // cell_row[4:0], cell_col[11:5], cell_char[19:12],
                                     // scrolled[20], cursor_row[25:21], cursor_col[32:26]
);

    tcw_pkg::t_ram_req           ram_req;
    logic [tcw_pkg::CHAR_W-1:0]  ram_rdata;
    tcw_pkg::t_result            res;
    logic                        res_valid;
    logic                        res_ready;

    tcw_pkg::t_result            r_out;
    logic                        r_out_valid;

    // The output register takes a new result when it is empty or draining.
    assign res_ready = !r_out_valid || i_m_tready;

    tcw_screen_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    tcw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_op        (i_s_tuser),
        .i_char      (i_s_tdata[7:0]),
        .i_rd_row    (i_s_tdata[12:8]),
        .i_rd_col    (i_s_tdata[19:13]),
        .o_res       (res),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_ram       (ram_req),
        .i_rdata     (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.wrote;
    assign o_m_tdata  = {7'd0, r_out.cursor_col, r_out.cursor_row, r_out.scrolled,
                         r_out.cell_char, r_out.cell_col, r_out.cell_row};

endmodule
